/* src/smvp_pkg.sv */
// shared types, codes and limits of the sparse matrix vector product unit
package smvp_pkg;

   // fixed field widths
   localparam int ROW_WIDTH   = 4;
   localparam int COL_WIDTH   = 4;
   localparam int DATA_WIDTH  = 16;
   localparam int SUM_WIDTH   = 40;
   localparam int CSR_WIDTH   = 5;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int ROW_LIMIT   = 16;
   localparam int LIMIT_WIDTH = 9;

   // parameter defaults
   localparam int DEF_MAX_ROWS    = 16;
   localparam int DEF_MAX_COLS    = 16;
   localparam int DEF_MAX_ENTRIES = 64;
   localparam int DEF_VALUE_WIDTH = 16;

   // command codes
   localparam logic [1:0] CMD_INSERT  = 2'd0;
   localparam logic [1:0] CMD_LOAD    = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [1:0] CMD_CLEAR   = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_PRODUCT   = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_ROWS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NUM_COLS = 2'd1;

   typedef struct packed {
      logic [1:0]                  command;
      logic [ROW_WIDTH-1:0]        row_index;
      logic [COL_WIDTH-1:0]        col_index;
      logic signed [DATA_WIDTH-1:0] data_value;
   } req_type;

   typedef struct packed {
      logic [ROW_WIDTH-1:0]        result_row;
      logic signed [SUM_WIDTH-1:0] row_sum;
      logic                        last;
      logic [1:0]                  status;
   } rsp_type;

   // control from the sequencer to the accumulator
   typedef struct packed {
      logic                 clear;
      logic                 mac_valid;
      logic [ROW_WIDTH-1:0] mac_row;
      logic [ROW_WIDTH-1:0] emit_row;
   } acc_ctrl_type;

endpackage

/* src/sparse_matrix_vector_product_unit.sv */
// sparse matrix vector product unit: entry store, vector store and sequencer
//
//  channel  direction  handshake        carries
//  req_     in         valid / stall    req_type command and operands
//  rsp_     out        valid / stall    rsp_type row sum or status
//  csr_     in         valid / ready    register index and data
//
// insert, load and clear complete in the idle state; an error result loads the output register.
// compute scans the store (one entry read per cycle from the entry memory), waits for the scan
// pipeline to drain, then reads the accumulator and writes the output register for each row.
// reset clears the entry count, valid bits and sequencer state, and sets both registers to 16.
// no request is taken during a compute run or while a result is stalled at the output.
module sparse_matrix_vector_product_unit #(
   parameter int MAX_ROWS    = smvp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS    = smvp_pkg::DEF_MAX_COLS,
   parameter int MAX_ENTRIES = smvp_pkg::DEF_MAX_ENTRIES,
   parameter int VALUE_WIDTH = smvp_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  smvp_pkg::req_type                      req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output smvp_pkg::rsp_type                      rsp_payload,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [smvp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [smvp_pkg::CSR_WIDTH-1:0]         csr_data
);
   import smvp_pkg::*;

   localparam int VEC_DEPTH = (MAX_COLS < ROW_LIMIT) ? MAX_COLS : ROW_LIMIT;
   localparam int VIW       = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
   localparam int EAW       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW        = $clog2(MAX_ENTRIES + 1);
   localparam int EW        = ROW_WIDTH + COL_WIDTH + VALUE_WIDTH;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_DRAIN   = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT_WR = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CSR_WIDTH-1:0]  num_rows_ff, num_cols_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         scan_idx_ff, scan_idx_in;
   logic [4:0]            emit_row_ff, emit_row_in;

   logic [LIMIT_WIDTH-1:0] rows_lim, cols_lim;
   logic [4:0]             rows_out;

   logic                  req_xfer;
   logic                  out_free;
   logic                  rsp_valid_ff;
   rsp_type               rsp_payload_ff;
   logic                  rsp_load;
   rsp_type               rsp_next;

   logic signed [VALUE_WIDTH-1:0] in_value;

   logic [EW-1:0]         ent_mem [MAX_ENTRIES];
   logic [EW-1:0]         ent_rd_ff;
   logic                  ent_we;
   logic                  p1_valid_ff, p1_valid_in;

   logic signed [VALUE_WIDTH-1:0] vec_mem [VEC_DEPTH];
   logic [VEC_DEPTH-1:0]  vec_valid_ff;
   logic                  vec_we;
   logic signed [VALUE_WIDTH-1:0] vec_rd_ff;
   logic                  p2_vvalid_ff;
   logic                  p2_valid_ff;
   logic [ROW_WIDTH-1:0]  p2_row_ff;
   logic signed [VALUE_WIDTH-1:0] p2_value_ff;

   logic [ROW_WIDTH-1:0]  ent_row;
   logic [COL_WIDTH-1:0]  ent_col;
   logic signed [VALUE_WIDTH-1:0] ent_value;

   acc_ctrl_type          acc_ctrl;
   logic signed [VALUE_WIDTH-1:0] mac_element;
   logic signed [SUM_WIDTH-1:0]   acc_sum;
   logic                  acc_busy;

   // input value taken as its low bits, or zero extended when the value width is wider
   generate
      if (VALUE_WIDTH <= DATA_WIDTH) begin : g_narrow
         assign in_value = req_payload.data_value[VALUE_WIDTH-1:0];
      end else begin : g_wide
         assign in_value = {{(VALUE_WIDTH-DATA_WIDTH){1'b0}}, req_payload.data_value};
      end
   endgenerate

   // register limits with out-of-range values clamped
   always_comb begin
      if (num_rows_ff == '0) begin
         rows_lim = LIMIT_WIDTH'(1);
      end else if (LIMIT_WIDTH'(num_rows_ff) > LIMIT_WIDTH'(MAX_ROWS)) begin
         rows_lim = LIMIT_WIDTH'(MAX_ROWS);
      end else begin
         rows_lim = LIMIT_WIDTH'(num_rows_ff);
      end
      if (num_cols_ff == '0) begin
         cols_lim = LIMIT_WIDTH'(1);
      end else if (LIMIT_WIDTH'(num_cols_ff) > LIMIT_WIDTH'(MAX_COLS)) begin
         cols_lim = LIMIT_WIDTH'(MAX_COLS);
      end else begin
         cols_lim = LIMIT_WIDTH'(num_cols_ff);
      end
      rows_out = (rows_lim > LIMIT_WIDTH'(ROW_LIMIT)) ? 5'(ROW_LIMIT) : rows_lim[4:0];
   end

   // configuration writes
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= CSR_WIDTH'(ROW_LIMIT);
         num_cols_ff <= CSR_WIDTH'(ROW_LIMIT);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_ROWS: num_rows_ff <= csr_data;
            CSR_NUM_COLS: num_cols_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input transfer
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_xfer  = req_valid && !req_stall;

   // entry fields of the scan read
   assign ent_row   = ent_rd_ff[EW-1 -: ROW_WIDTH];
   assign ent_col   = ent_rd_ff[VALUE_WIDTH +: COL_WIDTH];
   assign ent_value = ent_rd_ff[VALUE_WIDTH-1:0];

   // sequencer and command decode
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      emit_row_in = emit_row_ff;
      ent_we      = 1'b0;
      vec_we      = 1'b0;
      p1_valid_in = 1'b0;
      rsp_load    = 1'b0;
      rsp_next    = '0;
      rsp_next.last = 1'b1;
      acc_ctrl    = '0;
      acc_ctrl.emit_row = emit_row_ff[ROW_WIDTH-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               case (req_payload.command)
                  CMD_INSERT: begin
                     rsp_next.result_row = req_payload.row_index;
                     if ((LIMIT_WIDTH'(req_payload.row_index) >= rows_lim) ||
                         (LIMIT_WIDTH'(req_payload.col_index) >= cols_lim)) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = STATUS_BAD_INDEX;
                     end else if (count_ff >= CW'(MAX_ENTRIES)) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = STATUS_FULL;
                     end else begin
                        ent_we   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_LOAD: begin
                     if (LIMIT_WIDTH'(req_payload.col_index) >= cols_lim) begin
                        rsp_load        = 1'b1;
                        rsp_next.status = STATUS_BAD_INDEX;
                     end else begin
                        vec_we = 1'b1;
                     end
                  end
                  CMD_COMPUTE: begin
                     acc_ctrl.clear = 1'b1;
                     scan_idx_in    = '0;
                     state_in       = ST_SCAN;
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff < count_ff) begin
               p1_valid_in = 1'b1;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff && !acc_busy) begin
               emit_row_in = '0;
               state_in    = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               rsp_load            = 1'b1;
               rsp_next.result_row = emit_row_ff[ROW_WIDTH-1:0];
               rsp_next.row_sum    = acc_sum;
               rsp_next.status     = STATUS_PRODUCT;
               rsp_next.last       = (emit_row_ff + 1'b1 == rows_out);
               if (emit_row_ff + 1'b1 == rows_out) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_row_in = emit_row_ff + 1'b1;
                  state_in    = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // multiply-accumulate request from the third scan stage
      acc_ctrl.mac_valid = p2_valid_ff;
      acc_ctrl.mac_row   = p2_row_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         emit_row_ff  <= '0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         scan_idx_ff <= scan_idx_in;
         emit_row_ff <= emit_row_in;
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p1_valid_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff <= rsp_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // entry memory
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[count_ff[EAW-1:0]] <= {req_payload.row_index, req_payload.col_index,
                                        in_value};
      end
      ent_rd_ff <= ent_mem[scan_idx_ff[EAW-1:0]];
   end

   // vector memory, read at the column of the entry just read
   always_ff @(posedge clock) begin
      if (vec_we) begin
         vec_mem[req_payload.col_index[VIW-1:0]] <= in_value;
      end
      vec_rd_ff   <= vec_mem[ent_col[VIW-1:0]];
      p2_row_ff   <= ent_row;
      p2_value_ff <= ent_value;
   end

   // vector valid bits: an element never loaded since clear reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vec_valid_ff <= '0;
         p2_vvalid_ff <= 1'b0;
      end else begin
         p2_vvalid_ff <= vec_valid_ff[ent_col[VIW-1:0]];
         if (req_xfer && (req_payload.command == CMD_CLEAR)) begin
            vec_valid_ff <= '0;
         end else if (vec_we) begin
            vec_valid_ff[req_payload.col_index[VIW-1:0]] <= 1'b1;
         end
      end
   end

   assign mac_element = p2_vvalid_ff ? vec_rd_ff : '0;

   smvp_accum #(
      .MAX_ROWS    (MAX_ROWS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (acc_ctrl),
      .mac_value   (p2_value_ff),
      .mac_element (mac_element),
      .rd_sum      (acc_sum),
      .busy        (acc_busy)
   );

`ifndef ASSERT_OFF
   // entry count stays within the store
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("entry count beyond store depth");

   // results are read only after the scan pipeline has drained
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_RD) |-> (!p1_valid_ff && !p2_valid_ff && !acc_busy))
      else $error("accumulator read while scan in flight");

   // output row stays within the rows in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_WR) |-> (emit_row_ff < rows_out))
      else $error("output row beyond rows in use");

   // an accepted compute starts the scan
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_payload.command == CMD_COMPUTE)) |=> (state_ff == ST_SCAN))
      else $error("compute did not start scan");
`endif

endmodule

/* src/smvp_accum.sv */
// row accumulator memory with multiply, read-modify-write and forwarding
module smvp_accum #(
   parameter int MAX_ROWS    = smvp_pkg::DEF_MAX_ROWS,
   parameter int VALUE_WIDTH = smvp_pkg::DEF_VALUE_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  smvp_pkg::acc_ctrl_type               ctrl,
   input  logic signed [VALUE_WIDTH-1:0]        mac_value,
   input  logic signed [VALUE_WIDTH-1:0]        mac_element,
   output logic signed [smvp_pkg::SUM_WIDTH-1:0] rd_sum,
   output logic                                 busy
);
   import smvp_pkg::*;

   localparam int ACC_DEPTH = (MAX_ROWS < ROW_LIMIT) ? MAX_ROWS : ROW_LIMIT;
   localparam int AIW       = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int PW        = 2 * VALUE_WIDTH;

   logic signed [SUM_WIDTH-1:0] acc_mem [ACC_DEPTH];
   logic [ACC_DEPTH-1:0]        acc_valid_ff;
   logic signed [SUM_WIDTH-1:0] rd_data_ff;
   logic                        rd_valid_ff;
   logic [AIW-1:0]              rd_addr;

   logic signed [PW-1:0]        prod_full;
   logic signed [SUM_WIDTH-1:0] prod_ext;
   logic signed [SUM_WIDTH-1:0] prod_ff;
   logic [AIW-1:0]              prod_row_ff;
   logic                        prod_valid_ff;

   logic                        fwd_valid_ff;
   logic [AIW-1:0]              fwd_row_ff;
   logic signed [SUM_WIDTH-1:0] fwd_data_ff;

   logic signed [SUM_WIDTH-1:0] base;
   logic signed [SUM_WIDTH-1:0] new_sum;

   // product of entry value and vector element, fitted to the sum width
   assign prod_full = mac_value * mac_element;
   generate
      if (PW >= SUM_WIDTH) begin : g_trunc
         assign prod_ext = prod_full[SUM_WIDTH-1:0];
      end else begin : g_sext
         assign prod_ext = {{(SUM_WIDTH-PW){prod_full[PW-1]}}, prod_full};
      end
   endgenerate

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.mac_valid;
      end
      prod_ff     <= prod_ext;
      prod_row_ff <= ctrl.mac_row[AIW-1:0];
   end

   // read address: incoming row during a scan, output row otherwise
   assign rd_addr = ctrl.mac_valid ? ctrl.mac_row[AIW-1:0] : ctrl.emit_row[AIW-1:0];

   // base of the add, forwarded when the previous write hit the same row
   always_comb begin
      if (fwd_valid_ff && (fwd_row_ff == prod_row_ff)) begin
         base = fwd_data_ff;
      end else if (rd_valid_ff) begin
         base = rd_data_ff;
      end else begin
         base = '0;
      end
   end

   assign new_sum = base + prod_ff;

   // memory read and write back
   always_ff @(posedge clock) begin
      rd_data_ff <= acc_mem[rd_addr];
      if (prod_valid_ff) begin
         acc_mem[prod_row_ff] <= new_sum;
      end
   end

   // row valid bits and forwarding register
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= acc_valid_ff[rd_addr];
         fwd_valid_ff <= prod_valid_ff;
         if (ctrl.clear) begin
            acc_valid_ff <= '0;
         end else if (prod_valid_ff) begin
            acc_valid_ff[prod_row_ff] <= 1'b1;
         end
      end
      fwd_row_ff  <= prod_row_ff;
      fwd_data_ff <= new_sum;
   end

   assign rd_sum = rd_valid_ff ? rd_data_ff : '0;
   assign busy   = prod_valid_ff;

endmodule

/* tb/sv/testbench.sv */
// testbench for the sparse matrix vector product unit with a self-checking response predictor
module testbench;
   import smvp_pkg::*;

   localparam int ENTRY_CAPACITY = DEF_MAX_ENTRIES;
   localparam int ROW_CAPACITY   = DEF_MAX_ROWS;
   localparam int COL_CAPACITY   = DEF_MAX_COLS;
   localparam int SETTLE_CYCLES  = 150;
   localparam int HOLD_CYCLES    = 200;
   localparam int FILL_INSERTS   = 66;
   localparam int TIMEOUT_UNITS  = 2_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0] csr_data = '0;

   // mirror of the block state
   logic [ROW_WIDTH-1:0] entry_rows [ENTRY_CAPACITY];
   logic [COL_WIDTH-1:0] entry_cols [ENTRY_CAPACITY];
   logic signed [DATA_WIDTH-1:0] entry_values [ENTRY_CAPACITY];
   logic signed [DATA_WIDTH-1:0] vector_elems [COL_CAPACITY] = '{default: '0};
   int entry_total = 0;
   logic [CSR_WIDTH-1:0] rows_setting = 5'd16;
   logic [CSR_WIDTH-1:0] cols_setting = 5'd16;

   req_type command_queue [$];
   rsp_type awaited_responses [$];
   int queued_total = 0;
   int accepted_total = 0;
   int failures = 0;

   // idling state of both sides
   int unsigned send_gap = 0;
   bit send_idling = 1'b1;
   int unsigned stall_left = 0;
   bit stall_idling = 1'b1;
   int unsigned hold_left = 0;
   bit hold_done = 1'b0;

   sparse_matrix_vector_product_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // out of range settings fall back to the nearest legal count
   function automatic int unsigned effective_count(input logic [CSR_WIDTH-1:0] setting,
                                                   input int unsigned limit);
      if (setting == 0) return 1;
      if (setting > limit) return limit;
      return setting;
   endfunction

   // mostly short idle stretches, a few long ones
   function automatic int unsigned idle_length();
      int unsigned draw = $urandom_range(0, 15);
      if (draw < 9) return 0;
      if (draw < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // update the mirror state and queue the responses that one command causes
   function automatic void apply_command(input req_type item);
      int unsigned rows;
      int unsigned cols;
      rsp_type response;
      logic signed [SUM_WIDTH-1:0] sum;
      logic signed [SUM_WIDTH-1:0] product;
      rows = effective_count(rows_setting, ROW_CAPACITY);
      cols = effective_count(cols_setting, COL_CAPACITY);
      response = '0;
      response.last = 1'b1;
      case (item.command)
         CMD_INSERT: begin
            response.result_row = item.row_index;
            if (item.row_index >= rows || item.col_index >= cols) begin
               response.status = STATUS_BAD_INDEX;
               awaited_responses = {awaited_responses, response};
            end else if (entry_total >= ENTRY_CAPACITY) begin
               response.status = STATUS_FULL;
               awaited_responses = {awaited_responses, response};
            end else begin
               entry_rows[entry_total] = item.row_index;
               entry_cols[entry_total] = item.col_index;
               entry_values[entry_total] = item.data_value;
               entry_total++;
            end
         end
         CMD_LOAD: begin
            if (item.col_index >= cols) begin
               response.status = STATUS_BAD_INDEX;
               awaited_responses = {awaited_responses, response};
            end else begin
               vector_elems[item.col_index] = item.data_value;
            end
         end
         CMD_COMPUTE: begin
            // one sum per row in use, stale columns still count
            for (int r = 0; r < rows; r++) begin
               sum = '0;
               for (int e = 0; e < entry_total; e++) begin
                  if (entry_rows[e] == r) begin
                     product = entry_values[e] * vector_elems[entry_cols[e]];
                     sum += product;
                  end
               end
               response.result_row = ROW_WIDTH'(r);
               response.row_sum = sum;
               response.last = (r == rows - 1);
               response.status = STATUS_PRODUCT;
               awaited_responses = {awaited_responses, response};
            end
         end
         default: begin
            entry_total = 0;
            foreach (vector_elems[i]) vector_elems[i] = '0;
         end
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_command(req_payload);
            accepted_total++;
            if ($urandom_range(0, 19) == 0) send_idling = !send_idling;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (command_queue.size() != 0) begin
               req_payload <= command_queue.pop_front();
               req_valid <= 1'b1;
               send_gap = send_idling ? idle_length() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and receiver stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // compare each transfer with the oldest awaited response
         if (rsp_valid && !rsp_stall) begin
            if (awaited_responses.size() == 0) begin
               $error("response with nothing awaited: row %0d sum %0d status %0d",
                      rsp_payload.result_row, rsp_payload.row_sum, rsp_payload.status);
               failures++;
            end else begin
               want = awaited_responses.pop_front();
               if (rsp_payload.result_row !== want.result_row) begin
                  $error("result_row: expected %0d, actual %0d",
                         want.result_row, rsp_payload.result_row);
                  failures++;
               end
               if (rsp_payload.row_sum !== want.row_sum) begin
                  $error("row_sum: expected %0d, actual %0d", want.row_sum, rsp_payload.row_sum);
                  failures++;
               end
               if (rsp_payload.last !== want.last) begin
                  $error("last: expected %0d, actual %0d", want.last, rsp_payload.last);
                  failures++;
               end
               if (rsp_payload.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
                  failures++;
               end
            end
         end
         if ($urandom_range(0, 63) == 0) stall_idling = !stall_idling;
         // one long hold-off while commands are still waiting to go in
         if (!hold_done && rsp_valid && command_queue.size() >= 4) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_idling) stall_left = idle_length();
         end
      end
   end

   // register write over the csr channel, mirror updated after the transfer
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] index,
                                 input logic [CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_NUM_ROWS) rows_setting = value;
      else if (index == CSR_NUM_COLS) cols_setting = value;
   endtask

   task automatic set_shape(input logic [CSR_WIDTH-1:0] rows, input logic [CSR_WIDTH-1:0] cols);
      write_register(CSR_NUM_ROWS, rows);
      write_register(CSR_NUM_COLS, cols);
   endtask

   task automatic send(input logic [1:0] command, input int unsigned row, input int unsigned col,
                       input int value);
      req_type item;
      item.command = command;
      item.row_index = ROW_WIDTH'(row);
      item.col_index = COL_WIDTH'(col);
      item.data_value = DATA_WIDTH'(value);
      command_queue = {command_queue, item};
      queued_total++;
   endtask

   // wait for every command to go in and every response to come out
   task automatic wait_idle();
      while (accepted_total != queued_total || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CSR_WIDTH-1:0] pick_setting();
      case ($urandom_range(0, 5))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return 5'd31;
         default: return CSR_WIDTH'($urandom_range(1, 16));
      endcase
   endfunction

   // index mostly inside the shape in use, sometimes anywhere
   function automatic int unsigned pick_index(input int unsigned in_use, input int unsigned bias);
      if ($urandom_range(0, 99) < bias) return $urandom_range(0, in_use - 1);
      return $urandom_range(0, 15);
   endfunction

   task automatic random_phase(input int count);
      int unsigned rows;
      int unsigned cols;
      int unsigned draw;
      set_shape(pick_setting(), pick_setting());
      rows = effective_count(rows_setting, ROW_CAPACITY);
      cols = effective_count(cols_setting, COL_CAPACITY);
      repeat (count) begin
         draw = $urandom_range(0, 19);
         if (draw < 8)
            send(CMD_INSERT, pick_index(rows, 80), pick_index(cols, 80), $urandom);
         else if (draw < 14)
            send(CMD_LOAD, $urandom_range(0, 15), pick_index(cols, 85), $urandom);
         else if (draw < 18)
            send(CMD_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
         else
            send(CMD_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
      end
      wait_idle();
   endtask

   // stimulus
   initial begin
      int unsigned rows;
      int unsigned cols;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset shape, value extremes at both corners of the matrix
      send(CMD_LOAD, 0, 0, -32768);
      send(CMD_LOAD, 0, 15, 32767);
      send(CMD_LOAD, 0, 3, -1);
      send(CMD_INSERT, 0, 0, -32768);
      send(CMD_INSERT, 15, 15, 32767);
      send(CMD_INSERT, 0, 15, 1);
      send(CMD_INSERT, 3, 3, 32767);
      send(CMD_INSERT, 15, 0, -32768);
      send(CMD_COMPUTE, 0, 0, 0);
      wait_idle();

      // shrunk shape: bad indexes, dropped rows, stale columns, clear
      set_shape(5'd4, 5'd5);
      send(CMD_INSERT, 4, 0, 5);
      send(CMD_INSERT, 0, 5, 5);
      send(CMD_LOAD, 0, 5, 9);
      send(CMD_LOAD, 0, 4, 21845);
      send(CMD_INSERT, 2, 4, -21846);
      send(CMD_COMPUTE, 15, 15, -1);
      send(CMD_CLEAR, 10, 5, 12345);
      send(CMD_COMPUTE, 0, 0, 0);
      wait_idle();

      // zero settings act as a single row and column
      set_shape(5'd0, 5'd0);
      send(CMD_INSERT, 0, 0, -2);
      send(CMD_INSERT, 1, 0, 3);
      send(CMD_INSERT, 0, 1, 3);
      send(CMD_LOAD, 0, 1, 4);
      send(CMD_LOAD, 0, 0, 7);
      send(CMD_COMPUTE, 0, 0, 0);
      wait_idle();

      // oversized settings act as the full shape
      set_shape(5'd31, 5'd31);
      send(CMD_COMPUTE, 0, 0, 0);
      wait_idle();

      random_phase(20);
      random_phase(20);

      // fill the entry store past capacity, then compute
      set_shape(pick_setting(), pick_setting());
      rows = effective_count(rows_setting, ROW_CAPACITY);
      cols = effective_count(cols_setting, COL_CAPACITY);
      send(CMD_CLEAR, 0, 0, 0);
      for (int c = 0; c < cols; c++)
         send(CMD_LOAD, 0, c, $urandom);
      repeat (FILL_INSERTS)
         send(CMD_INSERT, $urandom_range(0, rows - 1), $urandom_range(0, cols - 1), $urandom);
      send(CMD_COMPUTE, 0, 0, 0);
      wait_idle();

      random_phase(20);
      random_phase(20);

      if (failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // run limit
   initial begin
      #(TIMEOUT_UNITS);
      $display("Verification failed");
      $finish;
   end

endmodule
